// ----- sv/multi_mode_branch_predictor_assert.svh -----
// assertion macros for the branch predictor
`ifndef MULTI_MODE_BRANCH_PREDICTOR_ASSERT_SVH
`define MULTI_MODE_BRANCH_PREDICTOR_ASSERT_SVH

// same-cycle implication on the block clock
`define MMBP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication on the block clock
`define MMBP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/mmbp_pkg.sv -----
// shared types, constants and counter helpers of the branch predictor
package mmbp_pkg;

   localparam int PC_BITS_DEF     = 10;
   localparam int HIST_BITS_DEF   = 4;
   localparam int WEIGHT_BITS_DEF = 16;

   localparam int PC_FIELD_BITS  = 10;
   localparam int CSR_IDX_BITS   = 1;
   localparam int CSR_DATA_BITS  = 4;
   localparam int MODE_BITS      = 3;
   localparam int CBITS_BITS     = 4;
   localparam int CTR_BITS       = 8;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_BIMODAL = 3'd0,
      MODE_GSHARE  = 3'd1,
      MODE_LOCAL   = 3'd2,
      MODE_TOURN   = 3'd3,
      MODE_PERCEPT = 3'd4
   } mode_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_MODE  = 1'b0,
      CSR_CBITS = 1'b1
   } csr_idx_type;

   typedef enum logic [1:0] {
      CH_STRONG_LOCAL  = 2'd0,
      CH_WEAK_LOCAL    = 2'd1,
      CH_WEAK_GLOBAL   = 2'd2,
      CH_STRONG_GLOBAL = 2'd3
   } chooser_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD1,
      ST_RD2,
      ST_EXEC
   } state_type;

   localparam logic [MODE_BITS-1:0]  MODE_RESET  = MODE_GSHARE;
   localparam logic [CBITS_BITS-1:0] CBITS_RESET = 4'd2;
   localparam logic [CBITS_BITS-1:0] CBITS_MAX   = 4'd8;

   function automatic logic [CTR_BITS-1:0] count_max(input logic [CBITS_BITS-1:0] cb);
      logic [CTR_BITS:0] m;
      m = (9'd1 << cb) - 9'd1;
      return (cb >= CBITS_MAX) ? {CTR_BITS{1'b1}} : m[CTR_BITS-1:0];
   endfunction

   function automatic logic ctr_taken(input logic [CTR_BITS-1:0] v,
                                      input logic [CTR_BITS-1:0] cmax);
      return v > (cmax >> 1);
   endfunction

   function automatic logic [CTR_BITS-1:0] ctr_train(input logic [CTR_BITS-1:0] v,
                                                     input logic [CTR_BITS-1:0] cmax,
                                                     input logic taken);
      logic [CTR_BITS-1:0] c;
      c = (v > cmax) ? cmax : v;
      if (taken) begin
         return (c < cmax) ? c + 8'd1 : cmax;
      end
      return (c > 8'd0) ? c - 8'd1 : 8'd0;
   endfunction

endpackage

// ----- sv/mmbp_if.sv -----
// request, response and register-write channels of the branch predictor
interface mmbp_req_if;
   logic                              valid;
   logic                              ready;
   logic                              req_type;
   logic [mmbp_pkg::PC_FIELD_BITS-1:0] branch_pc;
   logic                              resolved_taken;
   modport source (output valid, req_type, branch_pc, resolved_taken, input ready);
   modport sink (input valid, req_type, branch_pc, resolved_taken, output ready);
endinterface

interface mmbp_rsp_if;
   logic valid;
   logic ready;
   logic predict_taken;
   modport source (output valid, predict_taken, input ready);
   modport sink (input valid, predict_taken, output ready);
endinterface

interface mmbp_csr_if;
   logic                              valid;
   logic                              ready;
   logic [mmbp_pkg::CSR_IDX_BITS-1:0]  index;
   logic [mmbp_pkg::CSR_DATA_BITS-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/multi_mode_branch_predictor.sv -----
// multi-mode branch predictor top level: bimodal, gshare, local, tournament, perceptron
// a request beat taken in ST_IDLE passes ST_RD1 and ST_RD2 to ST_EXEC, whose write-back
//   registers the response beat (or writes the tables on update); no new request is
//   taken before it, as two dependent ram reads (local history, then pattern counter)
//   precede it; reset: synchronous, a clearing pass over 2^(PC_BITS+HIST_BITS) entries
//   (16384 by default) zeroes all tables before the first request is taken
`include "multi_mode_branch_predictor_assert.svh"

module multi_mode_branch_predictor #(
   parameter int PC_BITS     = mmbp_pkg::PC_BITS_DEF,
   parameter int HIST_BITS   = mmbp_pkg::HIST_BITS_DEF,
   parameter int WEIGHT_BITS = mmbp_pkg::WEIGHT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   mmbp_req_if.sink    req_chan,
   mmbp_rsp_if.source  rsp_chan,
   mmbp_csr_if.sink    csr_chan
);
   import mmbp_pkg::*;

   localparam int CLR_BITS = PC_BITS + HIST_BITS;
   localparam int SUM_BITS = WEIGHT_BITS + HIST_BITS + 2;
   localparam int ROW_BITS = WEIGHT_BITS * (HIST_BITS + 1);

   // control state
   state_type                  state_ff, state_in;
   logic [CLR_BITS-1:0]        clr_ff, clr_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_taken_ff, rsp_taken_in;
   logic [MODE_BITS-1:0]       mode_ff;
   logic [CBITS_BITS-1:0]      cbits_ff;

   // architectural predictor state held in flops
   logic [HIST_BITS-1:0]       ghist_ff, ghist_in;
   chooser_type                chooser_ff, chooser_in;
   logic signed [SUM_BITS-1:0] last_sum_ff, last_sum_in;
   logic                       last_g_ff, last_g_in;
   logic                       last_l_ff, last_l_in;

   // captured request beat
   logic                       upd_ff;
   logic [PC_BITS-1:0]         pc_ff;
   logic                       taken_ff;

   // ram ports
   logic                       sh_we, hi_we, pt_we, wt_we;
   logic [PC_BITS-1:0]         sh_addr, sh_waddr, hi_waddr, wt_waddr;
   logic [CLR_BITS-1:0]        pt_addr, pt_waddr;
   logic [CTR_BITS-1:0]        sh_wdata, sh_rdata, pt_wdata, pt_rdata;
   logic [HIST_BITS-1:0]       hi_wdata, hi_rdata;
   logic [ROW_BITS-1:0]        wt_wdata, wt_rdata, wt_trained;

   mode_type                   mode;
   logic [CTR_BITS-1:0]        cmax;
   logic [PC_BITS-1:0]         gidx;
   logic                       g_guess, l_guess;
   logic                       exec_go;
   logic signed [SUM_BITS-1:0] p_sum;
   logic                       p_train;

   // modes beyond perceptron fall back to bimodal
   always_comb begin
      case (mode_ff)
         MODE_GSHARE:  mode = MODE_GSHARE;
         MODE_LOCAL:   mode = MODE_LOCAL;
         MODE_TOURN:   mode = MODE_TOURN;
         MODE_PERCEPT: mode = MODE_PERCEPT;
         default:      mode = MODE_BIMODAL;
      endcase
   end

   assign cmax = count_max(cbits_ff);

   // gshare index: history bits above the history width read as ones
   always_comb begin
      for (int i = 0; i < PC_BITS; i++) begin
         gidx[i] = pc_ff[i] ^ ((i < HIST_BITS) ? ghist_ff[(i < HIST_BITS) ? i : 0] : 1'b1);
      end
   end

   // read addresses follow the captured pc and stay put until the write-back
   assign sh_addr = (mode == MODE_GSHARE || mode == MODE_TOURN) ? gidx : pc_ff;
   assign pt_addr = {hi_rdata, pc_ff};

   assign g_guess = ctr_taken(sh_rdata, cmax);
   assign l_guess = ctr_taken(pt_rdata, cmax);

   // write-back waits only when a prediction finds the response register full and the receiver not ready
   assign exec_go = (state_ff == ST_EXEC) && (upd_ff || !rsp_valid_ff || rsp_chan.ready);

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.predict_taken = rsp_taken_ff;

   mmbp_perceptron #(
      .HIST_BITS   (HIST_BITS),
      .WEIGHT_BITS (WEIGHT_BITS),
      .SUM_BITS    (SUM_BITS),
      .ROW_BITS    (ROW_BITS)
   ) u_percept (
      .row      (wt_rdata),
      .ghist    (ghist_ff),
      .taken    (taken_ff),
      .last_sum (last_sum_ff),
      .theta    (cmax),
      .sum      (p_sum),
      .train    (p_train),
      .new_row  (wt_trained)
   );

   // bimodal and gshare counters
   mmbp_ram #(.WIDTH(CTR_BITS), .DEPTH(2**PC_BITS)) u_shared (
      .clock (clock), .we (sh_we), .waddr (sh_waddr), .wdata (sh_wdata),
      .raddr (sh_addr), .rdata (sh_rdata)
   );

   // per-branch local histories
   mmbp_ram #(.WIDTH(HIST_BITS), .DEPTH(2**PC_BITS)) u_lhist (
      .clock (clock), .we (hi_we), .waddr (hi_waddr), .wdata (hi_wdata),
      .raddr (pc_ff), .rdata (hi_rdata)
   );

   // second-level pattern counters, addressed {history, pc}
   mmbp_ram #(.WIDTH(CTR_BITS), .DEPTH(2**CLR_BITS)) u_pattern (
      .clock (clock), .we (pt_we), .waddr (pt_waddr), .wdata (pt_wdata),
      .raddr (pt_addr), .rdata (pt_rdata)
   );

   // perceptron rows: bias in the low slice, then one weight per history bit
   mmbp_ram #(.WIDTH(ROW_BITS), .DEPTH(2**PC_BITS)) u_weights (
      .clock (clock), .we (wt_we), .waddr (wt_waddr), .wdata (wt_wdata),
      .raddr (pc_ff), .rdata (wt_rdata)
   );

   // sequencer, table write-back and predictor state update
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      ghist_in     = ghist_ff;
      chooser_in   = chooser_ff;
      last_sum_in  = last_sum_ff;
      last_g_in    = last_g_ff;
      last_l_in    = last_l_ff;
      rsp_taken_in = rsp_taken_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      sh_we    = 1'b0;
      hi_we    = 1'b0;
      pt_we    = 1'b0;
      wt_we    = 1'b0;
      sh_waddr = sh_addr;
      hi_waddr = pc_ff;
      pt_waddr = pt_addr;
      wt_waddr = pc_ff;
      sh_wdata = ctr_train(sh_rdata, cmax, taken_ff);
      pt_wdata = ctr_train(pt_rdata, cmax, taken_ff);
      hi_wdata = HIST_BITS'({hi_rdata, taken_ff});
      wt_wdata = wt_trained;

      case (state_ff)
         ST_CLEAR: begin
            // one entry of every table per cycle
            sh_we    = 1'b1;
            hi_we    = 1'b1;
            pt_we    = 1'b1;
            wt_we    = 1'b1;
            sh_waddr = clr_ff[PC_BITS-1:0];
            hi_waddr = clr_ff[PC_BITS-1:0];
            pt_waddr = clr_ff;
            wt_waddr = clr_ff[PC_BITS-1:0];
            sh_wdata = '0;
            hi_wdata = '0;
            pt_wdata = '0;
            wt_wdata = '0;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == {CLR_BITS{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_RD1;
            end
         end
         ST_RD1: begin
            // first-level reads go out at the captured pc; their data and the pattern read follow in ST_RD2
            state_in = ST_RD2;
         end
         ST_RD2: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (exec_go) begin
               state_in = ST_IDLE;
               if (!upd_ff) begin
                  rsp_valid_in = 1'b1;
                  case (mode)
                     MODE_GSHARE: rsp_taken_in = g_guess;
                     MODE_LOCAL:  rsp_taken_in = l_guess;
                     MODE_TOURN: begin
                        last_g_in    = g_guess;
                        last_l_in    = l_guess;
                        rsp_taken_in = (chooser_ff >= CH_WEAK_GLOBAL) ? g_guess : l_guess;
                     end
                     MODE_PERCEPT: begin
                        last_sum_in  = p_sum;
                        rsp_taken_in = (p_sum >= 0);
                     end
                     default:     rsp_taken_in = g_guess;
                  endcase
               end else begin
                  case (mode)
                     MODE_GSHARE: begin
                        sh_we    = 1'b1;
                        ghist_in = HIST_BITS'({ghist_ff, taken_ff});
                     end
                     MODE_LOCAL: begin
                        pt_we = 1'b1;
                        hi_we = 1'b1;
                     end
                     MODE_TOURN: begin
                        // only the selected component trains
                        if (chooser_ff >= CH_WEAK_GLOBAL) begin
                           sh_we    = 1'b1;
                           ghist_in = HIST_BITS'({ghist_ff, taken_ff});
                        end else begin
                           pt_we = 1'b1;
                           hi_we = 1'b1;
                        end
                        if (last_l_ff == taken_ff && last_g_ff != taken_ff) begin
                           if (chooser_ff != CH_STRONG_LOCAL) begin
                              chooser_in = chooser_type'(chooser_ff - 2'd1);
                           end
                        end else if (last_g_ff == taken_ff && last_l_ff != taken_ff) begin
                           if (chooser_ff != CH_STRONG_GLOBAL) begin
                              chooser_in = chooser_type'(chooser_ff + 2'd1);
                           end
                        end
                     end
                     MODE_PERCEPT: begin
                        wt_we    = p_train;
                        ghist_in = HIST_BITS'({ghist_ff, taken_ff});
                     end
                     default: sh_we = 1'b1;
                  endcase
               end
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_RESET;
         cbits_ff     <= CBITS_RESET;
         ghist_ff     <= '0;
         chooser_ff   <= CH_WEAK_LOCAL;
         last_sum_ff  <= '0;
         last_g_ff    <= 1'b0;
         last_l_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         ghist_ff     <= ghist_in;
         chooser_ff   <= chooser_in;
         last_sum_ff  <= last_sum_in;
         last_g_ff    <= last_g_in;
         last_l_ff    <= last_l_in;
         // the user must send register writes only while idle; the block itself does not enforce it
         if (csr_chan.valid) begin
            case (csr_chan.index)
               CSR_MODE:  mode_ff  <= MODE_BITS'(csr_chan.data);
               CSR_CBITS: cbits_ff <= csr_chan.data;
               default: ;
            endcase
         end
      end
   end

   // request capture and response payload
   always_ff @(posedge clock) begin
      rsp_taken_ff <= rsp_taken_in;
      if (req_chan.valid && req_chan.ready) begin
         upd_ff   <= req_chan.req_type;
         pc_ff    <= PC_BITS'(req_chan.branch_pc);
         taken_ff <= req_chan.resolved_taken;
      end
   end

   // a prediction write-back into an empty response register starts a response beat
   `MMBP_ASSERT_NEXT(a_rsp_from_exec, !rsp_valid_ff && exec_go && !upd_ff, rsp_valid_ff,
      "prediction finished without a response beat")
   // tables are written only in the clearing pass or at write-back
   `MMBP_ASSERT_NOW(a_write_window, sh_we || hi_we || pt_we || wt_we,
      state_ff == ST_CLEAR || exec_go, "table write outside clear or write-back")
   // the chooser moves only on a tournament update
   `MMBP_ASSERT_NOW(a_chooser_move, chooser_in != chooser_ff,
      exec_go && upd_ff && mode == MODE_TOURN, "chooser moved outside a tournament update")
   // a stalled response is never overwritten
   `MMBP_ASSERT_NOW(a_no_overwrite, rsp_valid_ff && !rsp_chan.ready,
      !(exec_go && !upd_ff), "response overwritten while stalled")
endmodule

// ----- sv/mmbp_ram.sv -----
// generic single-port-write ram with registered read
module mmbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// ----- sv/mmbp_perceptron.sv -----
// perceptron sum and saturating weight training for one row
module mmbp_perceptron #(
   parameter int HIST_BITS   = mmbp_pkg::HIST_BITS_DEF,
   parameter int WEIGHT_BITS = mmbp_pkg::WEIGHT_BITS_DEF,
   parameter int SUM_BITS    = WEIGHT_BITS + HIST_BITS + 2,
   parameter int ROW_BITS    = WEIGHT_BITS * (HIST_BITS + 1)
) (
   input  logic [ROW_BITS-1:0]            row,
   input  logic [HIST_BITS-1:0]           ghist,
   input  logic                           taken,
   input  logic signed [SUM_BITS-1:0]     last_sum,
   input  logic [mmbp_pkg::CTR_BITS-1:0]  theta,
   output logic signed [SUM_BITS-1:0]     sum,
   output logic                           train,
   output logic [ROW_BITS-1:0]            new_row
);
   import mmbp_pkg::*;

   localparam logic signed [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
   localparam logic signed [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
   localparam logic signed [WEIGHT_BITS-1:0] W_ONE = {{(WEIGHT_BITS-1){1'b0}}, 1'b1};

   logic signed [SUM_BITS-1:0] acc;
   logic        [SUM_BITS-1:0] mag;
   logic signed [SUM_BITS-1:0] th;

   // bias plus or minus the low HIST_BITS+1 bits of each history weight, read as unsigned
   always_comb begin
      acc = SUM_BITS'(signed'(row[WEIGHT_BITS-1:0]));
      mag = '0;
      for (int i = 0; i < HIST_BITS; i++) begin
         mag = SUM_BITS'(row[(i+1)*WEIGHT_BITS +: HIST_BITS+1]);
         if (ghist[i]) begin
            acc = acc + signed'(mag);
         end else begin
            acc = acc - signed'(mag);
         end
      end
      sum = acc;
   end

   assign th    = signed'(SUM_BITS'(theta));
   assign train = taken ? !(last_sum > th) : !(last_sum < -th);

   always_comb begin
      logic                          inc;
      logic signed [WEIGHT_BITS-1:0] w;
      new_row = row;
      for (int j = 0; j <= HIST_BITS; j++) begin
         inc = (j == 0) ? taken : (ghist[(j == 0) ? 0 : j-1] == taken);
         w   = row[j*WEIGHT_BITS +: WEIGHT_BITS];
         if (inc) begin
            new_row[j*WEIGHT_BITS +: WEIGHT_BITS] = (w == W_MAX) ? w : w + W_ONE;
         end else begin
            new_row[j*WEIGHT_BITS +: WEIGHT_BITS] = (w == W_MIN) ? w : w - W_ONE;
         end
      end
   end
endmodule
